// File: sv/hsr_pkg.sv
// ----------------------------------------------------------------------------
// Halfband resampler package
// Shared item types, controller command bundle, mode and opcode codes.
// ----------------------------------------------------------------------------
package hsr_pkg;

    localparam int SEMI_LENGTH_DEF = 8;
    localparam int DATA_W          = 16;

    // Opcodes of an input item.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Mode register codes. Codes above MODE_INTERP are unused.
    localparam logic [2:0] MODE_SPLIT   = 3'd0;
    localparam logic [2:0] MODE_ANALYZE = 3'd1;
    localparam logic [2:0] MODE_SYNTH   = 3'd2;
    localparam logic [2:0] MODE_DECIM   = 3'd3;
    localparam logic [2:0] MODE_INTERP  = 3'd4;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] sample_first;
        logic signed [DATA_W-1:0] sample_second;
        logic [3:0]               coef_index;
        logic signed [DATA_W-1:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] low_band;
        logic signed [DATA_W-1:0] high_band;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_coef;
        logic       push;
        logic       mac;
        logic       load_out;
        logic       fir_even;
        logic [2:0] mode;
    } t_dp_cmd;

endpackage

// File: sv/hsr_datapath.sv
// ----------------------------------------------------------------------------
// Halfband resampler datapath
// Sample windows and coefficients as rotating shift lines, one shared
// multiply-accumulate, and the rounding and saturating output stage.
// ----------------------------------------------------------------------------
module hsr_datapath
    import hsr_pkg::*;
#(
    parameter int SEMI_LENGTH = SEMI_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_data,
    output t_out_item o_out_data
);

    localparam int TAPS  = 2 * SEMI_LENGTH;
    localparam int IW    = $clog2(TAPS);
    localparam int ACC_W = 2 * DATA_W + IW;
    localparam int X_W   = ACC_W + 2;
    localparam logic signed [X_W-1:0] MAX_V = X_W'(32767);
    localparam logic signed [X_W-1:0] MIN_V = X_W'(-32768);

    logic signed [DATA_W-1:0] r_even [TAPS];
    logic signed [DATA_W-1:0] r_odd  [TAPS];
    logic signed [DATA_W-1:0] r_coef [TAPS];
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_d;
    t_out_item                r_out;

    logic                     push_even;
    logic                     push_odd;
    logic signed [DATA_W-1:0] even_in;
    logic signed [DATA_W-1:0] odd_in;
    logic signed [DATA_W:0]   sum_w;
    logic signed [DATA_W:0]   diff_w;
    logic signed [DATA_W-1:0] even_tail;
    logic signed [DATA_W-1:0] odd_tail;
    logic signed [DATA_W-1:0] fir_tap;
    logic signed [2*DATA_W-1:0] prod;
    logic signed [X_W-1:0]    dx;
    logic signed [X_W-1:0]    accx;
    t_out_item                n_out;
    logic                     coef_ok;
    logic [IW-1:0]            coef_addr;

    function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [DATA_W:0] v);
        if (v > 17'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    // Round to nearest with ties upward, by 2^16 or 2^15, then saturate.
    function automatic logic signed [DATA_W-1:0] rnd_sat(
        input logic signed [X_W-1:0] x,
        input logic                  k16
    );
        logic signed [X_W-1:0] half;
        logic signed [X_W-1:0] b;
        logic signed [X_W-1:0] q;
        half     = '0;
        half[15] = k16;
        half[14] = !k16;
        b        = x + half;
        q        = k16 ? (b >>> 16) : (b >>> 15);
        if (q > MAX_V) begin
            return 16'sh7FFF;
        end else if (q < MIN_V) begin
            return 16'sh8000;
        end else begin
            return q[DATA_W-1:0];
        end
    endfunction

    always_comb begin
        sum_w     = {i_in_data.sample_first[DATA_W-1], i_in_data.sample_first}
                  + {i_in_data.sample_second[DATA_W-1], i_in_data.sample_second};
        diff_w    = {i_in_data.sample_first[DATA_W-1], i_in_data.sample_first}
                  - {i_in_data.sample_second[DATA_W-1], i_in_data.sample_second};
        push_even = 1'b0;
        push_odd  = 1'b0;
        even_in   = i_in_data.sample_first;
        odd_in    = i_in_data.sample_first;
        case (i_cmd.mode)
            MODE_SPLIT: begin
                push_even = !i_cmd.fir_even;
                push_odd  = i_cmd.fir_even;
            end
            MODE_ANALYZE, MODE_DECIM: begin
                push_even = 1'b1;
                push_odd  = 1'b1;
                even_in   = i_in_data.sample_second;
            end
            MODE_SYNTH: begin
                push_even = 1'b1;
                push_odd  = 1'b1;
                even_in   = sat_w(sum_w);
                odd_in    = sat_w(diff_w);
            end
            MODE_INTERP: begin
                push_even = 1'b1;
                push_odd  = 1'b1;
            end
            default: begin
                push_even = 1'b0;
                push_odd  = 1'b0;
            end
        endcase
        push_even = push_even && i_cmd.push;
        push_odd  = push_odd && i_cmd.push;
        // A push drops the oldest entry; a rotation moves it to the newest place.
        even_tail = push_even ? even_in : r_even[0];
        odd_tail  = push_odd ? odd_in : r_odd[0];
    end

    // Windows shift on a push and rotate once per tap during accumulation,
    // so after a full pass every entry is back in its place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_even[i] <= '0;
                r_odd[i]  <= '0;
            end
        end else begin
            if (push_even || i_cmd.mac) begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_even[i] <= r_even[i+1];
                end
                r_even[TAPS-1] <= even_tail;
            end
            if (push_odd || i_cmd.mac) begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_odd[i] <= r_odd[i+1];
                end
                r_odd[TAPS-1] <= odd_tail;
            end
        end
    end

    assign coef_ok   = ({28'd0, i_in_data.coef_index} < 32'(TAPS));
    assign coef_addr = IW'(i_in_data.coef_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                r_coef[i] <= r_coef[i+1];
            end
            r_coef[TAPS-1] <= r_coef[0];
        end else if (i_cmd.load_coef && coef_ok) begin
            r_coef[coef_addr] <= i_in_data.coef_value;
        end
    end

    assign fir_tap = i_cmd.fir_even ? r_even[0] : r_odd[0];
    assign prod    = r_coef[0] * fir_tap;

    // The delay entry after a push is the entry one place newer before it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_acc <= '0;
            r_d   <= i_cmd.fir_even ? r_odd[SEMI_LENGTH] : r_even[SEMI_LENGTH];
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
    end

    always_comb begin
        dx   = X_W'($signed({r_d, 15'd0}));
        accx = X_W'(r_acc);
        case (i_cmd.mode)
            MODE_SPLIT: begin
                n_out.low_band  = rnd_sat(dx + accx, 1'b1);
                n_out.high_band = rnd_sat(dx - accx, 1'b1);
            end
            MODE_ANALYZE: begin
                n_out.low_band  = rnd_sat(dx + accx, 1'b0);
                n_out.high_band = rnd_sat(accx - dx, 1'b0);
            end
            MODE_DECIM: begin
                n_out.low_band  = rnd_sat(dx + accx, 1'b0);
                n_out.high_band = '0;
            end
            MODE_SYNTH, MODE_INTERP: begin
                n_out.low_band  = r_d;
                n_out.high_band = rnd_sat(accx, 1'b0);
            end
            default: begin
                n_out.low_band  = '0;
                n_out.high_band = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

// File: sv/hsr_ctrl.sv
// ----------------------------------------------------------------------------
// Halfband resampler controller
// Mode register, split phase, tap sequencing and the output valid flag.
// ----------------------------------------------------------------------------
module hsr_ctrl
    import hsr_pkg::*;
#(
    parameter int SEMI_LENGTH = SEMI_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_opcode,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd
);

    localparam int TAPS = 2 * SEMI_LENGTH;
    localparam int IW   = $clog2(TAPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_FINISH
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_cnt;
    logic [2:0]    r_mode;
    logic          r_phase;
    logic          r_fir_even;
    logic          r_out_valid;

    logic          in_acc;
    logic          mode_ok;
    logic          split_now;

    assign in_acc    = i_in_valid && o_in_ready;
    assign mode_ok   = (r_mode <= MODE_INTERP);
    assign split_now = (r_mode == MODE_SPLIT);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_coef = in_acc && (i_opcode == OP_LOAD);
        o_cmd.push      = in_acc && (i_opcode == OP_RUN) && mode_ok;
        o_cmd.mac       = (r_state == S_MAC);
        o_cmd.load_out  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
        o_cmd.fir_even  = o_cmd.push ? (split_now && r_phase) : r_fir_even;
        o_cmd.mode      = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_mode      <= MODE_SPLIT;
            r_phase     <= 1'b0;
            r_fir_even  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_out_valid <= (r_out_valid && !i_out_ready) || o_cmd.load_out;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.push) begin
                        r_state    <= S_MAC;
                        r_cnt      <= '0;
                        r_fir_even <= o_cmd.fir_even;
                        if (split_now) begin
                            r_phase <= !r_phase;
                        end
                    end
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IW'(TAPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_push_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_state == S_MAC) && (r_cnt == '0))
        else $error("accepted sample beat did not start the tap sequence");

    a_full_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && ($past(r_state) == S_MAC) |-> $past(r_cnt) == IW'(TAPS - 1))
        else $error("accumulation ended before a full pass over the taps");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.push && split_now) |=> $stable(r_phase))
        else $error("split phase changed without a split-mode sample beat");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished result not presented on the output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !r_out_valid || i_out_ready)
        else $error("output register loaded over a pending result");

endmodule

// File: sv/halfband_resampler_core.sv
// ----------------------------------------------------------------------------
// Halfband resampler core
// Two-branch polyphase halfband filter: split, analyzer, synthesizer,
// decimator and interpolator on Q1.15 samples.
// ----------------------------------------------------------------------------
// Usage:
// Input beats arrive on i_in_valid / o_in_ready with an item struct. A load
// beat (opcode 0) writes one branch coefficient and gives no result. A run
// beat (opcode 1) pushes samples into the windows and gives one result beat
// on o_out_valid / i_out_ready, unless the mode register holds an unused
// code, in which case the beat is dropped. A run beat is pushed, then runs
// one tap per cycle through the single shared multiply-accumulate, and is
// then rounded and saturated into the output register. No new beat is taken
// until the result is in the output register. If the receiver stalls, the
// block still finishes one more item and then holds it until the output
// register frees up. The mode register is written through i_cfg_we /
// i_cfg_wdata while the block is idle; this binds the user, as the block
// itself leaves it unchecked. Synchronous reset clears both windows, the
// split phase, the mode and the output valid flag; coefficients must be
// loaded before use.
// ----------------------------------------------------------------------------
module halfband_resampler_core
    import hsr_pkg::*;
#(
    parameter int SEMI_LENGTH = SEMI_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);

    t_dp_cmd cmd;

    hsr_ctrl #(
        .SEMI_LENGTH (SEMI_LENGTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_data.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    hsr_datapath #(
        .SEMI_LENGTH (SEMI_LENGTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// File: sim/halfband_resampler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Halfband resampler core testbench
// Loads the branch coefficients and runs the split, analyzer, synthesizer,
// decimator and interpolator modes. It also sends run beats under the unused
// mode codes. Directed beats cover the sample extremes. Random beats follow,
// with input bursts and gaps and a stalling receiver. A cycle-free model of
// the windows and the rounding predicts each result beat, and the checker
// compares every beat with that prediction.
// ----------------------------------------------------------------------------
module halfband_resampler_core_test;
    import hsr_pkg::*;

    localparam int SEMI         = SEMI_LENGTH_DEF;
    localparam int TAPS         = 2 * SEMI;
    localparam int LATENCY      = TAPS + 2;
    localparam int SETTLE       = 3 * LATENCY;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 600;
    localparam int MAX_REPORTS  = 10;

    localparam logic [2:0] MODE_FIRST_UNUSED = MODE_INTERP + 3'd1;
    localparam logic [2:0] MODE_TOP          = 3'b111;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_style_e;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_wdata = MODE_SPLIT;
    logic       in_valid  = 1'b0;
    t_in_item   in_data   = '0;
    logic       in_ready;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;

    // Filter state as the block should hold it.
    logic [2:0]         model_mode;
    logic               model_phase;
    logic signed [15:0] even_hist [TAPS];
    logic signed [15:0] odd_hist  [TAPS];
    logic signed [15:0] coef_tab  [TAPS];

    t_out_item    pending_results [$];
    t_out_item    want_beat;
    int           failures     = 0;
    int           useful_beats = 0;
    int           burst_left   = 0;
    int           idle_cycles  = 0;
    int           stall_left   = 0;
    ready_style_e stall_style  = READY_ALWAYS;

    halfband_resampler_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Divide by 2^k, rounding to nearest with ties upward, then saturate.
    function automatic logic signed [15:0] round_shift(longint x, int k);
        return sat16((x + (longint'(1) <<< (k - 1))) >>> k);
    endfunction

    function automatic longint tap_sum(bit from_odd);
        longint acc = 0;
        for (int i = 0; i < TAPS; i++) begin
            if (from_odd) acc += longint'(coef_tab[i]) * longint'(odd_hist[i]);
            else acc += longint'(coef_tab[i]) * longint'(even_hist[i]);
        end
        return acc;
    endfunction

    function automatic void shift_in(bit into_odd, logic signed [15:0] s);
        if (into_odd) begin
            for (int i = 0; i < TAPS - 1; i++) odd_hist[i] = odd_hist[i + 1];
            odd_hist[TAPS - 1] = s;
        end else begin
            for (int i = 0; i < TAPS - 1; i++) even_hist[i] = even_hist[i + 1];
            even_hist[TAPS - 1] = s;
        end
    endfunction

    // Updates the filter state for one accepted beat; returns 1 when the beat
    // produces a result.
    function automatic bit resample_beat(t_in_item it, output t_out_item res);
        longint             acc;
        longint             dly;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        res = '0;
        x0 = $signed(it.sample_first);
        x1 = $signed(it.sample_second);
        if (it.opcode == OP_LOAD) begin
            if (it.coef_index < TAPS) coef_tab[it.coef_index] = $signed(it.coef_value);
            return 1'b0;
        end
        case (model_mode)
            MODE_SPLIT: begin
                shift_in(model_phase, x0);
                dly = model_phase ? longint'(odd_hist[SEMI - 1]) : longint'(even_hist[SEMI - 1]);
                acc = tap_sum(!model_phase);
                model_phase = !model_phase;
                res.low_band  = round_shift(dly * 32768 + acc, 16);
                res.high_band = round_shift(dly * 32768 - acc, 16);
            end
            MODE_ANALYZE, MODE_DECIM: begin
                shift_in(1'b1, x0);
                acc = tap_sum(1'b1);
                shift_in(1'b0, x1);
                dly = longint'(even_hist[SEMI - 1]);
                res.low_band = round_shift(acc + dly * 32768, 15);
                if (model_mode == MODE_ANALYZE) res.high_band = round_shift(acc - dly * 32768, 15);
            end
            MODE_SYNTH: begin
                shift_in(1'b0, sat16(longint'(x0) + longint'(x1)));
                shift_in(1'b1, sat16(longint'(x0) - longint'(x1)));
                res.low_band  = even_hist[SEMI - 1];
                res.high_band = round_shift(tap_sum(1'b1), 15);
            end
            MODE_INTERP: begin
                shift_in(1'b0, x0);
                shift_in(1'b1, x0);
                res.low_band  = even_hist[SEMI - 1];
                res.high_band = round_shift(tap_sum(1'b1), 15);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        int v;
        v = $urandom_range(0, 511);
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3: return 16'(v - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_beat();
        t_in_item it;
        int       v;
        v = $urandom_range(0, 8191);
        it.opcode        = ($urandom_range(0, 9) == 0) ? OP_LOAD : OP_RUN;
        it.sample_first  = rand_sample();
        it.sample_second = rand_sample();
        it.coef_index    = 4'($urandom);
        // Mostly moderate taps so that results do not all saturate.
        it.coef_value    = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'(v - 4096);
        return it;
    endfunction

    function automatic t_in_item make_beat(logic op, logic signed [15:0] a,
                                           logic signed [15:0] b, logic [3:0] idx,
                                           logic signed [15:0] c);
        t_in_item it;
        it.opcode        = op;
        it.sample_first  = a;
        it.sample_second = b;
        it.coef_index    = idx;
        it.coef_value    = c;
        return it;
    endfunction

    // Valid is left high after acceptance; the caller either sends the next
    // beat in the same step or the burst logic lowers it.
    task automatic send_beat(t_in_item it);
        t_out_item res;
        int        gap;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (resample_beat(it, res)) begin
            pending_results.push_back(res);
            useful_beats++;
        end else if (it.opcode == OP_LOAD) begin
            useful_beats++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Holds the input until every pending result has been taken, then lets
    // the block finish any beat that produces no result.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [2:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        model_mode  = m;
    endtask

    task automatic test_coef_load();
        write_mode(MODE_SPLIT);
        for (int i = 0; i < TAPS; i++) begin
            send_beat(make_beat(OP_LOAD, rand_sample(), rand_sample(), 4'(i),
                                i[0] ? 16'sh7fff : 16'sh8000));
        end
    endtask

    task automatic test_split_mode();
        send_beat(make_beat(OP_RUN, 16'sh7fff, 16'sh0000, 4'd0, 16'sh0000));
        send_beat(make_beat(OP_RUN, 16'sh8000, 16'sh7fff, 4'd15, 16'sh7fff));
        send_beat(make_beat(OP_RUN, 16'sh0000, 16'sh8000, 4'd5, 16'sh8000));
        send_beat(make_beat(OP_RUN, 16'shffff, 16'sh0001, 4'd10, 16'sh1234));
        send_beat(make_beat(OP_RUN, 16'sh0001, 16'shffff, 4'd3, 16'shedcb));
        send_beat(make_beat(OP_RUN, 16'sh7fff, 16'sh7fff, 4'd7, 16'sh0001));
    endtask

    task automatic test_stream_modes();
        for (int m = MODE_ANALYZE; m <= MODE_INTERP; m++) begin
            drain();
            write_mode(3'(m));
            send_beat(make_beat(OP_RUN, 16'sh7fff, 16'sh7fff, 4'd1, 16'sh0000));
            send_beat(make_beat(OP_RUN, 16'sh8000, 16'sh7fff, 4'd2, 16'sh0000));
            send_beat(make_beat(OP_RUN, 16'sh8000, 16'sh8000, 4'd4, 16'sh0000));
        end
    endtask

    // Run beats under unused codes are dropped and must leave the windows and
    // the split phase alone; loads still take effect.
    task automatic test_unused_modes();
        for (int m = MODE_FIRST_UNUSED; m <= MODE_TOP; m++) begin
            drain();
            write_mode(3'(m));
            send_beat(make_beat(OP_RUN, 16'sh7fff, 16'sh8000, 4'd9, 16'sh0000));
        end
        send_beat(make_beat(OP_LOAD, 16'sh0000, 16'sh0000, 4'd8, 16'sh4000));
        drain();
        write_mode(MODE_SPLIT);
        send_beat(make_beat(OP_RUN, 16'sh1000, 16'sh0000, 4'd0, 16'sh0000));
        send_beat(make_beat(OP_RUN, 16'shf000, 16'sh0000, 4'd0, 16'sh0000));
    endtask

    task automatic test_random_traffic();
        int start;
        int phase_len;
        start = useful_beats;
        while (useful_beats - start < RANDOM_ITEMS) begin
            drain();
            if ($urandom_range(0, 7) == 0) write_mode(3'($urandom_range(MODE_FIRST_UNUSED, MODE_TOP)));
            else write_mode(3'($urandom_range(MODE_SPLIT, MODE_INTERP)));
            phase_len = $urandom_range(10, 80);
            for (int n = 0; n < phase_len; n++) begin
                send_beat(random_beat());
                if (n == phase_len / 2 && $urandom_range(0, 3) == 0) drain();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= ready_style_e'($urandom_range(0, 3));
            stall_left  <= $urandom_range(16, 256);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
            default:      out_ready <= (stall_left % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("unexpected result beat: low_band %0d high_band %0d",
                             $signed(out_data.low_band), $signed(out_data.high_band));
                end
            end else begin
                want_beat = pending_results.pop_front();
                if (out_data.low_band !== want_beat.low_band ||
                    out_data.high_band !== want_beat.high_band) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("result mismatch: low_band exp %0d got %0d, high_band exp %0d got %0d",
                                 $signed(want_beat.low_band), $signed(out_data.low_band),
                                 $signed(want_beat.high_band), $signed(out_data.high_band));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        model_mode  = MODE_SPLIT;
        model_phase = 1'b0;
        for (int i = 0; i < TAPS; i++) begin
            even_hist[i] = '0;
            odd_hist[i]  = '0;
            coef_tab[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_coef_load();
        test_split_mode();
        test_stream_modes();
        test_unused_modes();
        test_random_traffic();
        drain();
        if (failures == 0 && pending_results.size() == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
